FILE: rtl/core/ilst_pkg.sv
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared widths, command and status codes, and the control bundle that the
// top level broadcasts to every list cell.
// ----------------------------------------------------------------------------
package ilst_pkg;

  // Default list depth.
  localparam int CAPACITY_DEF = 64;

  // Fixed field widths.
  localparam int CMD_W     = 2;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 7;

  // Number of match bits examined per cycle while a search scans the chain.
  localparam int SCAN_W = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

  // Per-cycle control broadcast to all cells.
  typedef struct packed {
    logic ins;    // open a slot at the position and load the new value
    logic del;    // close the slot at the position
    logic cmp;    // compare every entry with the key and latch the match
    logic shift;  // move the match bits one scan group toward cell zero
  } ilst_ctrl_t;

endpackage

FILE: rtl/core/ilst_cell.sv
// ----------------------------------------------------------------------------
// Indexed list cell
// Holds one list entry and its search match bit. Takes its neighbor's entry
// on insert or delete, and a match bit from further up the chain on a scan.
// ----------------------------------------------------------------------------
module ilst_cell #(
  parameter int INDEX = 0,
  parameter int XW    = 7
) (
  input  logic                      clk,
  input  ilst_pkg::ilst_ctrl_t      ctrl,
  input  logic [XW-1:0]             pos,
  input  logic [XW-1:0]             cnt,
  input  logic [ilst_pkg::VAL_W-1:0] new_val,
  input  logic [ilst_pkg::VAL_W-1:0] left_val,
  input  logic [ilst_pkg::VAL_W-1:0] right_val,
  input  logic                      match_in,
  output logic [ilst_pkg::VAL_W-1:0] val,
  output logic                      match
);

  localparam logic [XW-1:0] IDX  = XW'(INDEX);
  localparam logic [XW-1:0] IDX1 = XW'(INDEX + 1);

  logic [ilst_pkg::VAL_W-1:0] val_r;
  logic                       match_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (IDX == pos) begin
        val_r <= new_val;
      end else if ((IDX > pos) && (IDX <= cnt)) begin
        val_r <= left_val;
      end
    end else if (ctrl.del) begin
      if ((IDX >= pos) && (IDX1 < cnt)) begin
        val_r <= right_val;
      end
    end
  end

  // Only occupied cells may report a match.
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      match_r <= (val_r == new_val) && (IDX < cnt);
    end else if (ctrl.shift) begin
      match_r <= match_in;
    end
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

FILE: rtl/core/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed 32-bit values with insert, delete and search by
// position or value, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Pulse start with a command while busy is low. Insert, delete and any
// unknown command finish in the accept cycle: the result beat appears on the
// next cycle and busy stays low, so a new command may be given every cycle.
// A search compares all entries in the accept cycle, then scans the match
// bits eight cells per cycle starting from position zero; busy stays high
// while groups of eight cells are examined, up to and including the group
// that holds the first match or the last occupied entry, and the result beat
// appears in the cycle in which busy falls. A search of an empty list answers
// like an insert, without going busy. Result beats are shown for exactly one
// cycle under out_valid and cannot be held off, so the receiver must take
// every beat as it comes. Stored entries need no clearing after reset.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
  parameter int CAPACITY = ilst_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ilst_pkg::CMD_W-1:0]        in_command,
  input  logic [ilst_pkg::POS_W-1:0]        in_position,
  input  logic signed [ilst_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  output logic [ilst_pkg::STAT_W-1:0]       out_status,
  output logic [ilst_pkg::POS_W-1:0]        out_found_position,
  output logic [ilst_pkg::CNT_OUT_W-1:0]    out_entry_count
);

  // Count width, width for position/count compares, and scan group size.
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = (CW > ilst_pkg::POS_W) ? CW : ilst_pkg::POS_W;
  localparam int GW  = (CAPACITY < ilst_pkg::SCAN_W) ? CAPACITY : ilst_pkg::SCAN_W;
  localparam int GIW = (GW > 1) ? $clog2(GW) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                           state_r, state_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic [CW-1:0]                    base_r, base_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [ilst_pkg::STAT_W-1:0]      out_status_r, out_status_nxt;
  logic [ilst_pkg::POS_W-1:0]       out_found_r, out_found_nxt;
  logic [ilst_pkg::CNT_OUT_W-1:0]   out_count_r, out_count_nxt;

  ilst_pkg::ilst_ctrl_t             ctrl;
  logic                             accept;
  logic [XW-1:0]                    cnt_x;
  logic [XW-1:0]                    pos_x;
  logic [XW-1:0]                    pos_eff;
  logic                             list_empty;
  logic                             list_full;
  logic [CW:0]                      base_sum;

  logic [ilst_pkg::VAL_W-1:0]       cell_val   [CAPACITY];
  logic [ilst_pkg::VAL_W-1:0]       left_val   [CAPACITY];
  logic [ilst_pkg::VAL_W-1:0]       right_val  [CAPACITY];
  logic [CAPACITY-1:0]              match_vec;
  logic [CAPACITY-1:0]              match_up;

  logic                             grp_hit;
  logic [GIW-1:0]                   grp_enc;

  assign accept     = start && (state_r == S_IDLE);
  assign cnt_x      = XW'(cnt_r);
  assign pos_x      = XW'(in_position);
  assign list_empty = (cnt_r == '0);
  assign list_full  = (cnt_r == CW'(CAPACITY));
  // An insert into an empty list always lands at position zero.
  assign pos_eff    = list_empty ? '0 : pos_x;
  assign base_sum   = (CW + 1)'(base_r) + (CW + 1)'(GW);

  // The cell row. Each cell sees its lower and upper neighbor's entry, and
  // the match bit one scan group further up, which is shifted down during a
  // scan so that the current group always sits in the lowest cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_lo
      assign left_val[i] = in_value;
    end else begin : g_lo
      assign left_val[i] = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_val[i] = in_value;
    end else begin : g_hi
      assign right_val[i] = cell_val[i+1];
    end
    if (i + GW < CAPACITY) begin : g_up
      assign match_up[i] = match_vec[i+GW];
    end else begin : g_up
      assign match_up[i] = 1'b0;
    end

    ilst_cell #(
      .INDEX (i),
      .XW    (XW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (pos_eff),
      .cnt       (cnt_x),
      .new_val   (in_value),
      .left_val  (left_val[i]),
      .right_val (right_val[i]),
      .match_in  (match_up[i]),
      .val       (cell_val[i]),
      .match     (match_vec[i])
    );
  end

  // First set match bit within the lowest scan group.
  always_comb begin
    grp_hit = 1'b0;
    grp_enc = '0;
    for (int k = GW - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        grp_hit = 1'b1;
        grp_enc = GIW'(k);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    base_nxt       = base_r;
    ctrl           = '0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_found_nxt = '0;
          unique case (in_command)
            ilst_pkg::CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (list_full) begin
                out_status_nxt = ilst_pkg::ST_FULL;
              end else if (!list_empty && (pos_x > cnt_x)) begin
                out_status_nxt = ilst_pkg::ST_BAD_POS;
              end else begin
                ctrl.ins       = 1'b1;
                cnt_nxt        = cnt_r + CW'(1);
                out_status_nxt = ilst_pkg::ST_DONE;
              end
            end
            ilst_pkg::CMD_DELETE: begin
              out_valid_nxt = 1'b1;
              if (list_empty) begin
                out_status_nxt = ilst_pkg::ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                out_status_nxt = ilst_pkg::ST_BAD_POS;
              end else begin
                ctrl.del       = 1'b1;
                cnt_nxt        = cnt_r - CW'(1);
                out_status_nxt = ilst_pkg::ST_DONE;
              end
            end
            ilst_pkg::CMD_SEARCH: begin
              if (list_empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ilst_pkg::ST_EMPTY;
              end else begin
                ctrl.cmp  = 1'b1;
                base_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ilst_pkg::ST_BAD_POS;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (grp_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ilst_pkg::ST_DONE;
          out_found_nxt  = ilst_pkg::POS_W'(base_r + CW'(grp_enc));
          state_nxt      = S_IDLE;
        end else if (base_sum >= (CW + 1)'(cnt_r)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ilst_pkg::ST_NOT_FOUND;
          out_found_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          ctrl.shift = 1'b1;
          base_nxt   = CW'(base_sum);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_count_nxt = ilst_pkg::CNT_OUT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy               = (state_r == S_SCAN);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_entry_count    = out_count_r;

  // A result beat is never shown while a scan is still running.
  a_beat_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat during scan");

  // The entry count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Only an accepted search command makes the block go busy.
  a_busy_by_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_command == ilst_pkg::CMD_SEARCH)))
    else $error("busy without a search");

  // Every accepted command other than a search answers on the next cycle.
  a_one_cycle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command != ilst_pkg::CMD_SEARCH)) |=> out_valid)
    else $error("missing result beat");

  // While scanning, the current group starts inside the occupied region.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (base_r < cnt_r))
    else $error("scan ran past the last entry");

endmodule
